FILE: rtl/srclex_pkg.sv
package srclex_pkg;

  localparam int NKEYS = 20;

  localparam logic [5:0] KIND_EOF     = 6'd0;
  localparam logic [5:0] KIND_ERROR   = 6'd1;
  localparam logic [5:0] KIND_STRING  = 6'd2;
  localparam logic [5:0] KIND_NUMBER  = 6'd3;
  localparam logic [5:0] KIND_IDENT   = 6'd4;
  localparam logic [5:0] KIND_KW_BASE = 6'd5;
  localparam logic [5:0] KIND_PLUS    = 6'd25;
  localparam logic [5:0] KIND_MINUS   = 6'd27;
  localparam logic [5:0] KIND_STAR    = 6'd29;
  localparam logic [5:0] KIND_POW     = 6'd31;
  localparam logic [5:0] KIND_POW_EQ  = 6'd32;
  localparam logic [5:0] KIND_SLASH   = 6'd33;
  localparam logic [5:0] KIND_PERCENT = 6'd35;
  localparam logic [5:0] KIND_ASSIGN  = 6'd37;
  localparam logic [5:0] KIND_ARROW   = 6'd39;
  localparam logic [5:0] KIND_BANG    = 6'd40;
  localparam logic [5:0] KIND_LT      = 6'd42;
  localparam logic [5:0] KIND_GT      = 6'd44;
  localparam logic [5:0] KIND_SEMI    = 6'd46;
  localparam logic [5:0] KIND_COLON   = 6'd47;
  localparam logic [5:0] KIND_COMMA   = 6'd48;
  localparam logic [5:0] KIND_LPAREN  = 6'd49;
  localparam logic [5:0] KIND_RPAREN  = 6'd50;
  localparam logic [5:0] KIND_LBRACE  = 6'd51;
  localparam logic [5:0] KIND_RBRACE  = 6'd52;
  localparam logic [5:0] KIND_DOT     = 6'd53;
  localparam logic [5:0] KIND_QUEST   = 6'd54;

  // keyword text, right justified, first char in the highest used byte
  localparam logic [63:0] KW_TEXT [NKEYS] = '{
    "put", "putln", "var", "const", "if", "elseif", "else", "for",
    "continue", "break", "fn", "return", "struct", "make", "this",
    "extends", "super", "and", "or", "xor"
  };

  localparam logic [3:0] KW_LEN [NKEYS] = '{
    4'd3, 4'd5, 4'd3, 4'd5, 4'd2, 4'd6, 4'd4, 4'd3, 4'd8, 4'd5,
    4'd2, 4'd6, 4'd6, 4'd4, 4'd4, 4'd7, 4'd5, 4'd3, 4'd2, 4'd3
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic        fin;
  } tok_t;

endpackage

FILE: rtl/source_lexer.sv
// channel  signals                                       direction
// in       in_valid in_stall ch end_of_source            source bytes, one per beat
// out      out_valid out_stall token_kind token_start    tokens, one per beat
//          token_length token_line is_final
//
// one source byte is taken per cycle while in_stall is low; the scan state updates in the same cycle
// a byte gives at most two tokens, which enter a four entry output queue
// in_stall rises while fewer than two queue entries are free
// rst is synchronous and returns the scan to offset 0, line 1
module source_lexer import srclex_pkg::*; #(
  parameter int OFFSET_BITS = 32,
  parameter longint unsigned MAX_TOKEN_LENGTH = 65535,
  parameter int LINE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ch,
  input  logic        end_of_source,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  token_kind,
  output logic [31:0] token_start,
  output logic [15:0] token_length,
  output logic [15:0] token_line,
  output logic        is_final
);

  localparam int LEN_BITS = $clog2(MAX_TOKEN_LENGTH + 64'd1);
  localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_TOKEN_LENGTH);

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_STRING, MODE_NUMBER, MODE_IDENT, MODE_OP, MODE_COMMENT
  } mode_t;

  mode_t                  mode, mode_next;
  logic                   la2, la2_next;
  logic [7:0]             pend, pend_next;
  logic [OFFSET_BITS-1:0] tbeg, tbeg_next;
  logic [LEN_BITS-1:0]    tlen, tlen_next;
  logic [LINE_BITS-1:0]   line, line_next;
  logic [LINE_BITS-1:0]   tline, tline_next;
  logic [NKEYS-1:0]       hits, hits_next;
  logic                   dots, dots_next;
  logic [OFFSET_BITS-1:0] off, off_next;
  logic                   cstar, cstar_next;

  tok_t       q [4];
  logic [1:0] wp, rp;
  logic [2:0] count;

  tok_t       toks [2];
  logic [1:0] ntok;
  logic       acc, pop, rescan, eos;

  function automatic tok_t mk(input logic [5:0] kind, input logic [31:0] start,
                              input logic [15:0] len, input logic [15:0] ln,
                              input logic fin);
    tok_t t;
    t.kind = kind;
    t.start = start;
    t.len = len;
    t.line = ln;
    t.fin = fin;
    return t;
  endfunction

  function automatic logic [5:0] op_base(input logic [7:0] c);
    case (c)
      "+": return KIND_PLUS;
      "-": return KIND_MINUS;
      "*": return KIND_STAR;
      "/": return KIND_SLASH;
      "%": return KIND_PERCENT;
      "=": return KIND_ASSIGN;
      "!": return KIND_BANG;
      "<": return KIND_LT;
      ">": return KIND_GT;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [5:0] single_op(input logic [7:0] c);
    case (c)
      ";": return KIND_SEMI;
      ":": return KIND_COLON;
      ",": return KIND_COMMA;
      "(": return KIND_LPAREN;
      ")": return KIND_RPAREN;
      "{": return KIND_LBRACE;
      "}": return KIND_RBRACE;
      ".": return KIND_DOT;
      "?": return KIND_QUEST;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic logic [NKEYS-1:0] kw_mask(input logic [NKEYS-1:0] h,
                                              input logic [LEN_BITS-1:0] p,
                                              input logic [7:0] c);
    logic [NKEYS-1:0] r;
    logic [2:0] idx;
    r = h;
    for (int k = 0; k < NKEYS; k++) begin
      idx = 3'(KW_LEN[k] - 4'(p[2:0]) - 4'd1);
      if (p >= LEN_BITS'(KW_LEN[k]) || KW_TEXT[k][{idx, 3'b000} +: 8] != c) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [5:0] ident_kind(input logic [NKEYS-1:0] h,
                                           input logic [LEN_BITS-1:0] n);
    logic [5:0] kind;
    kind = KIND_IDENT;
    for (int k = 0; k < NKEYS; k++) begin
      if (h[k] && n == LEN_BITS'(KW_LEN[k])) begin
        kind = 6'(KIND_KW_BASE + 6'(k));
      end
    end
    return kind;
  endfunction

  assign in_stall = count > 3'd2;
  assign acc = in_valid && !in_stall;
  assign out_valid = count != 3'd0;
  assign pop = out_valid && !out_stall;
  assign eos = end_of_source || ch == 8'd0;

  always_comb begin
    mode_next = mode;
    la2_next = la2;
    pend_next = pend;
    tbeg_next = tbeg;
    tlen_next = tlen;
    line_next = line;
    tline_next = tline;
    hits_next = hits;
    dots_next = dots;
    off_next = off + OFFSET_BITS'(1);
    cstar_next = cstar;
    toks[0] = '0;
    toks[1] = '0;
    ntok = 2'd0;
    rescan = 1'b0;
    if (eos) begin
      case (mode)
        MODE_STRING: begin
          toks[ntok[0]] = mk(KIND_ERROR, 32'(tbeg), 16'd0, 16'(tline), 1'b0);
          ntok = ntok + 2'd1;
        end
        MODE_NUMBER: begin
          toks[ntok[0]] = mk(KIND_NUMBER, 32'(tbeg), 16'(tlen), 16'(tline), 1'b0);
          ntok = ntok + 2'd1;
        end
        MODE_IDENT: begin
          toks[ntok[0]] = mk(ident_kind(hits, tlen), 32'(tbeg), 16'(tlen),
                             16'(tline), 1'b0);
          ntok = ntok + 2'd1;
        end
        MODE_OP: begin
          if (la2) begin
            toks[ntok[0]] = mk(KIND_POW, 32'(tbeg), 16'd2, 16'(tline), 1'b0);
          end else begin
            toks[ntok[0]] = mk(op_base(pend), 32'(tbeg), 16'd1, 16'(tline), 1'b0);
          end
          ntok = ntok + 2'd1;
        end
        default: ;
      endcase
      toks[ntok[0]] = mk(KIND_EOF, 32'(off), 16'd0, 16'(line), 1'b1);
      ntok = ntok + 2'd1;
      mode_next = MODE_IDLE;
      la2_next = 1'b0;
      pend_next = 8'd0;
      tbeg_next = '0;
      tlen_next = '0;
      line_next = LINE_BITS'(1);
      tline_next = LINE_BITS'(1);
      hits_next = '1;
      dots_next = 1'b0;
      off_next = '0;
      cstar_next = 1'b0;
    end else begin
      case (mode)
        MODE_STRING: begin
          if (ch == "\"") begin
            toks[ntok[0]] = mk(KIND_STRING, 32'(tbeg), 16'(tlen), 16'(tline), 1'b0);
            ntok = ntok + 2'd1;
            mode_next = MODE_IDLE;
          end else begin
            if (ch == "\n" && line != '1) line_next = line + LINE_BITS'(1);
            if (tlen != LEN_MAX) tlen_next = tlen + LEN_BITS'(1);
          end
        end
        MODE_COMMENT: begin
          if (cstar && ch == "/") begin
            cstar_next = 1'b0;
            mode_next = MODE_IDLE;
          end else begin
            cstar_next = ch == "*";
            if (ch == "\n" && line != '1) line_next = line + LINE_BITS'(1);
          end
        end
        MODE_NUMBER: begin
          if (is_digit(ch)) begin
            if (tlen != LEN_MAX) tlen_next = tlen + LEN_BITS'(1);
          end else if (ch == "." && !dots) begin
            dots_next = 1'b1;
            if (tlen != LEN_MAX) tlen_next = tlen + LEN_BITS'(1);
          end else begin
            toks[ntok[0]] = mk(KIND_NUMBER, 32'(tbeg), 16'(tlen), 16'(tline), 1'b0);
            ntok = ntok + 2'd1;
            mode_next = MODE_IDLE;
            rescan = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_alpha(ch) || is_digit(ch)) begin
            hits_next = kw_mask(hits, tlen, ch);
            if (tlen != LEN_MAX) tlen_next = tlen + LEN_BITS'(1);
          end else begin
            toks[ntok[0]] = mk(ident_kind(hits, tlen), 32'(tbeg), 16'(tlen),
                               16'(tline), 1'b0);
            ntok = ntok + 2'd1;
            mode_next = MODE_IDLE;
            rescan = 1'b1;
          end
        end
        MODE_OP: begin
          if (la2) begin
            la2_next = 1'b0;
            mode_next = MODE_IDLE;
            if (ch == "=") begin
              toks[ntok[0]] = mk(KIND_POW_EQ, 32'(tbeg), 16'd3, 16'(tline), 1'b0);
            end else begin
              toks[ntok[0]] = mk(KIND_POW, 32'(tbeg), 16'd2, 16'(tline), 1'b0);
              rescan = 1'b1;
            end
            ntok = ntok + 2'd1;
          end else if (pend == "/" && ch == "*") begin
            cstar_next = 1'b0;
            mode_next = MODE_COMMENT;
          end else if (pend == "*" && ch == "*") begin
            la2_next = 1'b1;
          end else begin
            mode_next = MODE_IDLE;
            if (ch == "=") begin
              toks[ntok[0]] = mk(op_base(pend) + 6'd1, 32'(tbeg), 16'd2,
                                 16'(tline), 1'b0);
            end else if (pend == "=" && ch == ">") begin
              toks[ntok[0]] = mk(KIND_ARROW, 32'(tbeg), 16'd2, 16'(tline), 1'b0);
            end else begin
              toks[ntok[0]] = mk(op_base(pend), 32'(tbeg), 16'd1, 16'(tline), 1'b0);
              rescan = 1'b1;
            end
            ntok = ntok + 2'd1;
          end
        end
        default: begin
          mode_next = MODE_IDLE;
          rescan = 1'b1;
        end
      endcase
      if (rescan) begin
        if (ch == "\"") begin
          tbeg_next = off + OFFSET_BITS'(1);
          tlen_next = '0;
          tline_next = line;
          mode_next = MODE_STRING;
        end else if (is_digit(ch)) begin
          tbeg_next = off;
          tlen_next = LEN_BITS'(1);
          tline_next = line;
          dots_next = 1'b0;
          mode_next = MODE_NUMBER;
        end else if (is_alpha(ch)) begin
          tbeg_next = off;
          tlen_next = LEN_BITS'(1);
          tline_next = line;
          hits_next = kw_mask('1, '0, ch);
          mode_next = MODE_IDENT;
        end else if (op_base(ch) != 6'd0) begin
          tbeg_next = off;
          tlen_next = '0;
          tline_next = line;
          pend_next = ch;
          la2_next = 1'b0;
          mode_next = MODE_OP;
        end else if (single_op(ch) != 6'd0) begin
          toks[ntok[0]] = mk(single_op(ch), 32'(off), 16'd1, 16'(line), 1'b0);
          ntok = ntok + 2'd1;
        end else if (ch == "\n" && line != '1) begin
          line_next = line + LINE_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      la2 <= 1'b0;
      pend <= 8'd0;
      tbeg <= '0;
      tlen <= '0;
      line <= LINE_BITS'(1);
      tline <= LINE_BITS'(1);
      hits <= '1;
      dots <= 1'b0;
      off <= '0;
      cstar <= 1'b0;
      wp <= 2'd0;
      rp <= 2'd0;
      count <= 3'd0;
    end else begin
      if (acc) begin
        mode <= mode_next;
        la2 <= la2_next;
        pend <= pend_next;
        tbeg <= tbeg_next;
        tlen <= tlen_next;
        line <= line_next;
        tline <= tline_next;
        hits <= hits_next;
        dots <= dots_next;
        off <= off_next;
        cstar <= cstar_next;
        wp <= wp + ntok;
      end
      if (pop) rp <= rp + 2'd1;
      count <= count + (acc ? {1'b0, ntok} : 3'd0) - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (ntok != 2'd0) q[wp] <= toks[0];
      if (ntok == 2'd2) q[wp + 2'd1] <= toks[1];
    end
  end

  assign token_kind = q[rp].kind;
  assign token_start = q[rp].start;
  assign token_length = q[rp].len;
  assign token_line = q[rp].line;
  assign is_final = q[rp].fin;

endmodule
